>>> hw/rtl/pbr_pkg.sv
`default_nettype none
package pbr_pkg;

    // Stage counts of the cell row
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 17;
    localparam int NUM_CELLS     = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int IDX_W         = $clog2(NUM_CELLS);

    // Field widths
    localparam int POS_W = 16;
    localparam int ANG_W = 15;
    localparam int RNG_W = 17;

    // Internal widths: CORDIC vector, angle accumulator, square root remainder and radicand
    localparam int XY_W  = 20;
    localparam int Z_W   = 20;
    localparam int REM_W = 20;
    localparam int RAD_W = 2 * RNG_W;

    // Angles in Q3.12
    localparam int HALF_PI = 6434;
    localparam int PI_Q    = 2 * HALF_PI;
    localparam int TWO_PI  = 4 * HALF_PI;

    localparam logic [RNG_W-1:0] DEADBAND_RESET = RNG_W'(410);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Everything one cell hands to the next
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic [REM_W-1:0]        rem;
        logic [RNG_W-1:0]        root;
        logic [RAD_W-1:0]        rad;
        quad_t                   quad;
        logic                    zero;
        logic signed [ANG_W-1:0] hd;
    } cell_data_t;

    // atan(2^-i) in Q.16
    function automatic logic signed [Z_W-1:0] atan_lookup(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (int'(i))
            0:       v = Z_W'(51472);
            1:       v = Z_W'(30386);
            2:       v = Z_W'(16055);
            3:       v = Z_W'(8150);
            4:       v = Z_W'(4091);
            5:       v = Z_W'(2047);
            6:       v = Z_W'(1024);
            7:       v = Z_W'(512);
            8:       v = Z_W'(256);
            9:       v = Z_W'(128);
            10:      v = Z_W'(64);
            11:      v = Z_W'(32);
            12:      v = Z_W'(16);
            13:      v = Z_W'(8);
            14:      v = Z_W'(4);
            15:      v = Z_W'(2);
            16:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pbr_prep.sv
`default_nettype none
module pbr_prep (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [pbr_pkg::POS_W-1:0]       target_x,
    input  wire logic [pbr_pkg::POS_W-1:0]       target_y,
    input  wire logic [pbr_pkg::POS_W-1:0]       own_x,
    input  wire logic [pbr_pkg::POS_W-1:0]       own_y,
    input  wire logic signed [pbr_pkg::ANG_W-1:0] own_heading,
    output logic                                 out_valid,
    output pbr_pkg::cell_data_t                  out_data
);
    import pbr_pkg::*;

    logic signed [POS_W:0] dx, dy, ndx, ndy;
    logic [POS_W-1:0]      a_next, b_next, adx_next, ady_next;
    quad_t                 quad_next;
    logic                  zero_next;

    logic                    v1_reg, v2_reg, v3_reg;
    logic [POS_W-1:0]        a1_reg, b1_reg, adx1_reg, ady1_reg;
    quad_t                   quad1_reg;
    logic                    zero1_reg;
    logic signed [ANG_W-1:0] hd1_reg;
    logic [POS_W-1:0]        a2_reg, b2_reg;
    logic [2*POS_W-1:0]      sqx2_reg, sqy2_reg;
    quad_t                   quad2_reg;
    logic                    zero2_reg;
    logic signed [ANG_W-1:0] hd2_reg;
    cell_data_t              d3_reg;

    // Differences and quadrant fold
    always_comb
    begin
        dx        = signed'({1'b0, target_x}) - signed'({1'b0, own_x});
        dy        = signed'({1'b0, target_y}) - signed'({1'b0, own_y});
        ndx       = -dx;
        ndy       = -dy;
        adx_next  = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
        ady_next  = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
        zero_next = 1'b0;
        if (dy > 0 && dx > 0)
        begin
            quad_next = QUAD_0;
            a_next    = dx[POS_W-1:0];
            b_next    = dy[POS_W-1:0];
        end
        else if (dy > 0)
        begin
            quad_next = QUAD_1;
            a_next    = dy[POS_W-1:0];
            b_next    = ndx[POS_W-1:0];
        end
        else if (dx < 0)
        begin
            quad_next = QUAD_2;
            a_next    = ndx[POS_W-1:0];
            b_next    = ndy[POS_W-1:0];
        end
        else
        begin
            // Fourth quadrant; a target along +x or on top of the follower gets bearing zero
            quad_next = QUAD_3;
            a_next    = ndy[POS_W-1:0];
            b_next    = dx[POS_W-1:0];
            zero_next = (dy == 0);
        end
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance payload: fold, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a_next;
            b1_reg    <= b_next;
            adx1_reg  <= adx_next;
            ady1_reg  <= ady_next;
            quad1_reg <= quad_next;
            zero1_reg <= zero_next;
            hd1_reg   <= own_heading;

            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            sqx2_reg  <= (2*POS_W)'(adx1_reg) * (2*POS_W)'(adx1_reg);
            sqy2_reg  <= (2*POS_W)'(ady1_reg) * (2*POS_W)'(ady1_reg);
            quad2_reg <= quad1_reg;
            zero2_reg <= zero1_reg;
            hd2_reg   <= hd1_reg;

            d3_reg.x    <= signed'(XY_W'(a2_reg));
            d3_reg.y    <= signed'(XY_W'(b2_reg));
            d3_reg.z    <= '0;
            d3_reg.rem  <= '0;
            d3_reg.root <= '0;
            d3_reg.rad  <= RAD_W'(sqx2_reg) + RAD_W'(sqy2_reg);
            d3_reg.quad <= quad2_reg;
            d3_reg.zero <= zero2_reg;
            d3_reg.hd   <= hd2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule
`default_nettype wire

>>> hw/rtl/pbr_cell.sv
`default_nettype none
module pbr_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [pbr_pkg::IDX_W-1:0] cell_idx,
    input  wire logic                      in_valid,
    input  wire pbr_pkg::cell_data_t       in_data,
    output logic                           out_valid,
    output pbr_pkg::cell_data_t            out_data
);
    import pbr_pkg::*;

    logic signed [XY_W-1:0] xs, ys;
    logic [REM_W-1:0]       rem_sh, trial;
    cell_data_t             d_next;
    logic                   v_reg;
    cell_data_t             d_reg;

    always_comb
    begin
        d_next = in_data;
        xs     = in_data.x >>> cell_idx;
        ys     = in_data.y >>> cell_idx;

        // One CORDIC vectoring rotation
        if (cell_idx < IDX_W'(CORDIC_STAGES))
        begin
            if (in_data.y > 0)
            begin
                d_next.x = in_data.x + ys;
                d_next.y = in_data.y - xs;
                d_next.z = in_data.z + atan_lookup(cell_idx);
            end
            else
            begin
                d_next.x = in_data.x - ys;
                d_next.y = in_data.y + xs;
                d_next.z = in_data.z - atan_lookup(cell_idx);
            end
        end

        // One root digit from the next pair of radicand bits
        rem_sh = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
        trial  = REM_W'({in_data.root, 2'b01});
        if (cell_idx < IDX_W'(SQRT_STEPS))
        begin
            d_next.rad = {in_data.rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                d_next.rem  = rem_sh - trial;
                d_next.root = {in_data.root[RNG_W-2:0], 1'b1};
            end
            else
            begin
                d_next.rem  = rem_sh;
                d_next.root = {in_data.root[RNG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule
`default_nettype wire

>>> hw/rtl/pbr_finish.sv
`default_nettype none
module pbr_finish (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire pbr_pkg::cell_data_t       in_data,
    input  wire logic [pbr_pkg::RNG_W-1:0] deadband,
    output logic                           out_valid,
    output logic signed [pbr_pkg::ANG_W-1:0] heading_error,
    output logic [pbr_pkg::RNG_W-1:0]      range_out
);
    import pbr_pkg::*;

    logic signed [Z_W-1:0]   zr;
    logic [ANG_W-1:0]        zc, offs;
    logic [ANG_W:0]          bsum;
    logic [ANG_W-1:0]        bearing_next;
    logic signed [ANG_W+1:0] err;
    logic signed [ANG_W+1:0] err_next;
    logic [RNG_W-1:0]        rng_next;

    logic                    v1_reg, v2_reg;
    logic [ANG_W-1:0]        bearing_reg;
    logic signed [ANG_W-1:0] hd_reg;
    logic [RNG_W-1:0]        root_reg;
    logic signed [ANG_W-1:0] err_reg;
    logic [RNG_W-1:0]        rng_reg;

    // Round the angle to Q.12, clamp, add quadrant base, wrap below two pi; the zero flag forces bearing zero
    always_comb
    begin
        zr = (in_data.z + Z_W'(8)) >>> 4;
        if (zr < 0)
            zc = '0;
        else if (zr > Z_W'(HALF_PI))
            zc = ANG_W'(HALF_PI);
        else
            zc = zr[ANG_W-1:0];
        case (in_data.quad)
            QUAD_0:  offs = '0;
            QUAD_1:  offs = ANG_W'(HALF_PI);
            QUAD_2:  offs = ANG_W'(2 * HALF_PI);
            QUAD_3:  offs = ANG_W'(3 * HALF_PI);
            default: offs = '0;
        endcase
        bsum = {1'b0, offs} + {1'b0, zc};
        if (in_data.zero)
            bearing_next = '0;
        else if (bsum >= (ANG_W+1)'(TWO_PI))
            bearing_next = ANG_W'(bsum - (ANG_W+1)'(TWO_PI));
        else
            bearing_next = bsum[ANG_W-1:0];
    end

    // Subtract heading and wrap once; apply deadband
    always_comb
    begin
        err = signed'({2'b00, bearing_reg}) - (ANG_W+2)'(hd_reg);
        if (err > (ANG_W+2)'(PI_Q))
            err_next = err - (ANG_W+2)'(TWO_PI);
        else if (err < -(ANG_W+2)'(PI_Q))
            err_next = err + (ANG_W+2)'(TWO_PI);
        else
            err_next = err;
        rng_next = (root_reg < deadband) ? '0 : root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bearing_reg <= bearing_next;
            hd_reg      <= in_data.hd;
            root_reg    <= in_data.root;
            err_reg     <= err_next[ANG_W-1:0];
            rng_reg     <= rng_next;
        end
    end

    assign out_valid     = v2_reg;
    assign heading_error = err_reg;
    assign range_out     = rng_reg;

endmodule
`default_nettype wire

>>> hw/rtl/pursuit_bearing_range.sv
// Pipeline: prep registers, a register per cell, finish registers; the cell row is as long as
// the larger of the two (16 CORDIC stages, 17 root digits).
// Throughput: one transaction per cycle; the whole pipeline holds when the result is
// stalled, so s_tready follows m_tready whenever the output register is full.
// Reset: rst_n clears all valid bits and loads deadband_reg with 410 (0.1 in Q5.12).
`default_nettype none
module pursuit_bearing_range (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // target_x[15:0], target_y[31:16], own_x[47:32], own_y[63:48], own_heading[78:64]
    input  wire logic [79:0]               s_tdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // heading_error[14:0], range_out[31:15]
    output logic [31:0]                    m_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic                      cfg_wr_en,
    input  wire logic [pbr_pkg::RNG_W-1:0] cfg_wr_data
);
    import pbr_pkg::*;

    logic                    advance;
    logic [RNG_W-1:0]        deadband_reg;
    logic                    vchain [NUM_CELLS+1];
    cell_data_t              dchain [NUM_CELLS+1];
    logic signed [ANG_W-1:0] heading_error;
    logic [RNG_W-1:0]        range_out;

    // Move every stage unless a finished result is waiting and not taken
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadband_reg <= DEADBAND_RESET;
        else if (cfg_wr_en)
            deadband_reg <= cfg_wr_data;
    end

    pbr_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (s_tvalid),
        .target_x    (s_tdata[15:0]),
        .target_y    (s_tdata[31:16]),
        .own_x       (s_tdata[47:32]),
        .own_y       (s_tdata[63:48]),
        .own_heading (s_tdata[78:64]),
        .out_valid   (vchain[0]),
        .out_data    (dchain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        pbr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .cell_idx  (IDX_W'(g)),
            .in_valid  (vchain[g]),
            .in_data   (dchain[g]),
            .out_valid (vchain[g+1]),
            .out_data  (dchain[g+1])
        );
    end

    pbr_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (vchain[NUM_CELLS]),
        .in_data       (dchain[NUM_CELLS]),
        .deadband      (deadband_reg),
        .out_valid     (m_tvalid),
        .heading_error (heading_error),
        .range_out     (range_out)
    );

    assign m_tdata = {range_out, heading_error};

endmodule
`default_nettype wire

>>> bench/pursuit_bearing_range_tb.sv
`timescale 1ns / 100ps

module pursuit_bearing_range_tb;
    import pbr_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int PIPE_LAT   = 3 + NUM_CELLS + 2;
    localparam int CYCLE_CAP  = 400000;

    // atan(2^-i) in Q.16 for the vectoring iterations
    localparam longint ATAN_Q16 [0:23] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    // One pose pair, target_x in the lowest bits
    typedef struct packed {
        logic signed [ANG_W-1:0] own_heading;
        logic [POS_W-1:0]        own_y;
        logic [POS_W-1:0]        own_x;
        logic [POS_W-1:0]        target_y;
        logic [POS_W-1:0]        target_x;
    } pose_pair_t;

    // One turn command, heading_error in the lowest bits
    typedef struct packed {
        logic [RNG_W-1:0]        range_out;
        logic signed [ANG_W-1:0] heading_error;
    } turn_cmd_t;

    class bearing_range_scoreboard;
        turn_cmd_t        expected_turns[$];
        logic [RNG_W-1:0] deadband;
        int               errors;
        int               accepted;
        int               checked;
        int               clipped;

        function new();
            deadband = DEADBAND_RESET;
        endfunction

        function int pending();
            return expected_turns.size();
        endfunction

        // Angle of (a, b) within one quadrant, Q3.12, clamped to [0, HALF_PI]
        function longint quadrant_angle(longint a, longint b);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            x = a;
            y = b;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q16[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q16[i];
                end
            end
            z = (z + 8) >>> 4;
            if (z < 0)
                z = 0;
            if (z > HALF_PI)
                z = HALF_PI;
            return z;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned probe;
            res = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 0)
            begin
                if (v >= res + probe)
                begin
                    v = v - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
            return res;
        endfunction

        function turn_cmd_t predict_turn(pose_pair_t p);
            longint          dx;
            longint          dy;
            longint          a;
            longint          b;
            longint          bearing;
            longint          err;
            longint unsigned rng;
            quad_t           q;
            turn_cmd_t       t;
            dx = longint'(p.target_x) - longint'(p.own_x);
            dy = longint'(p.target_y) - longint'(p.own_y);

            // Coincident points and targets straight along +x give bearing zero
            if ((dx == 0 && dy == 0) || (dy == 0 && dx > 0))
            begin
                bearing = 0;
            end
            else
            begin
                if (dy > 0 && dx > 0)
                begin
                    q = QUAD_0;
                    a = dx;
                    b = dy;
                end
                else if (dy > 0)
                begin
                    q = QUAD_1;
                    a = dy;
                    b = -dx;
                end
                else if (dx < 0)
                begin
                    q = QUAD_2;
                    a = -dx;
                    b = -dy;
                end
                else
                begin
                    q = QUAD_3;
                    a = -dy;
                    b = dx;
                end
                bearing = longint'(q) * HALF_PI + quadrant_angle(a, b);
            end
            if (bearing >= TWO_PI)
                bearing = bearing - TWO_PI;

            // Wrap the turn once into [-pi, pi]
            err = bearing - longint'(p.own_heading);
            if (err > PI_Q)
                err = err - TWO_PI;
            else if (err < -PI_Q)
                err = err + TWO_PI;

            rng = root_floor(longint'(dx * dx) + longint'(dy * dy));
            if (rng < deadband)
            begin
                if (rng != 0)
                    clipped++;
                rng = 0;
            end

            t.heading_error = ANG_W'(err);
            t.range_out     = RNG_W'(rng);
            return t;
        endfunction

        function void note_pose(pose_pair_t p);
            accepted++;
            expected_turns.push_back(predict_turn(p));
        endfunction

        function void check_turn(turn_cmd_t got);
            turn_cmd_t want;
            if (expected_turns.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: heading_error %0d, range_out %0d",
                         $time, got.heading_error, got.range_out);
                return;
            end
            want = expected_turns.pop_front();
            checked++;
            if (got.heading_error !== want.heading_error)
            begin
                errors++;
                $display("%0t: heading_error mismatch: expected %0d, actual %0d",
                         $time, want.heading_error, got.heading_error);
            end
            if (got.range_out !== want.range_out)
            begin
                errors++;
                $display("%0t: range_out mismatch: expected %0d, actual %0d",
                         $time, want.range_out, got.range_out);
            end
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic [79:0]       s_tdata     = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [31:0]       m_tdata;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [RNG_W-1:0]  cfg_wr_data = '0;

    bearing_range_scoreboard sb = new();
    bit                      idle_on = 1'b0;
    int                      stall_left = 0;
    int                      cycle_count = 0;
    int                      settings_used = 1;

    pursuit_bearing_range dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready = 1'b0;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_turn(turn_cmd_t'(m_tdata));
    end

    function automatic pose_pair_t make_pose(int tx, int ty, int ox, int oy, int hd);
        pose_pair_t p;
        p.target_x    = POS_W'(tx);
        p.target_y    = POS_W'(ty);
        p.own_x       = POS_W'(ox);
        p.own_y       = POS_W'(oy);
        p.own_heading = ANG_W'(hd);
        return p;
    endfunction

    function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] v, int span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return POS_W'(t);
    endfunction

    function automatic pose_pair_t random_pose();
        pose_pair_t p;
        int         d;
        p.target_x = POS_W'($urandom);
        p.target_y = POS_W'($urandom);
        p.own_x    = POS_W'($urandom);
        p.own_y    = POS_W'($urandom);
        case ($urandom_range(0, 9))
            5, 6:
            begin
                // Close approach: ranges around the deadband
                p.target_x = nudge(p.own_x, 600);
                p.target_y = nudge(p.own_y, 600);
            end
            7:
            begin
                if ($urandom_range(0, 1) == 1)
                    p.target_x = p.own_x;
                else
                    p.target_y = p.own_y;
            end
            8:
            begin
                p.target_x = p.own_x;
                p.target_y = p.own_y;
            end
            9:
            begin
                // Diagonal offsets land on quadrant midpoints
                d = $urandom_range(1, 20000);
                p.target_x = POS_W'(int'(nudge(p.own_x, 0))
                                    + (($urandom_range(0, 1) == 1) ? d : -d));
                p.target_y = POS_W'(int'(p.own_y) + (($urandom_range(0, 1) == 1) ? d : -d));
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            p.own_heading = ANG_W'($urandom);
        else
            p.own_heading = ANG_W'(int'($urandom_range(0, TWO_PI)) - PI_Q);
        return p;
    endfunction

    // Drive one pose pair and hold it until accepted; call and return at a falling edge
    task automatic send_pose(input pose_pair_t p);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {1'b0, p};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pose(p);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result is back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_deadband(input logic [RNG_W-1:0] v);
        drain_results();
        repeat (PIPE_LAT) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.deadband = v;
        settings_used++;
    endtask

    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain_results();
            send_pose(random_pose());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed poses with the reset deadband
        send_pose(make_pose(1000, 1000, 1000, 1000, 0));
        send_pose(make_pose(0, 0, 0, 0, 16383));
        send_pose(make_pose(5000, 2000, 1000, 2000, 0));
        send_pose(make_pose(1000, 5000, 1000, 1000, HALF_PI));
        send_pose(make_pose(0, 3000, 4000, 3000, PI_Q));
        send_pose(make_pose(3000, 0, 3000, 4000, -PI_Q));
        send_pose(make_pose(3000, 3000, 1000, 1000, -HALF_PI));
        send_pose(make_pose(1000, 3000, 3000, 1000, 100));
        send_pose(make_pose(1000, 1000, 3000, 3000, -100));
        send_pose(make_pose(3000, 1000, 1000, 3000, 5000));
        send_pose(make_pose(65535, 65535, 0, 0, -16384));
        send_pose(make_pose(0, 0, 65535, 65535, 16383));
        send_pose(make_pose(65535, 0, 0, 65535, PI_Q));
        send_pose(make_pose(0, 65535, 65535, 0, -PI_Q));
        send_pose(make_pose(1410, 500, 1000, 500, 0));
        send_pose(make_pose(1409, 500, 1000, 500, 0));
        send_pose(make_pose(65535, 1, 0, 2, 0));
        send_pose(make_pose(0, 65535, 1, 0, 100));
        send_pose(make_pose(1, 0, 0, 65535, -100));
        send_pose(make_pose(65535, 1, 0, 2, -16384));
        send_pose(make_pose(2000, 2000, 2000, 2000, 16383));
        send_pose(make_pose(2000, 2000, 2000, 2000, PI_Q + 1));
        send_pose(make_pose(2000, 2000, 2000, 2000, -PI_Q - 1));

        // Random phases across deadband settings, extremes included
        idle_on = 1'b1;
        set_deadband(RNG_W'(0));
        run_random(200, -1);

        idle_on = 1'b0;
        set_deadband(RNG_W'(92682));
        run_random(80, -1);

        idle_on = 1'b1;
        set_deadband(RNG_W'($urandom_range(1, 8192)));
        run_random(250, 120);

        set_deadband(RNG_W'(131071));
        run_random(60, -1);

        // Last part runs with no idling
        idle_on = 1'b0;
        set_deadband(DEADBAND_RESET);
        run_random(330, -1);

        drain_results();
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("Sent %0d pose pairs and checked %0d turn commands over %0d deadband settings",
                 sb.accepted, sb.checked, settings_used);
        $display("Deadband forced %0d nonzero ranges to zero", sb.clipped);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pbr_pkg.sv
hw/rtl/pbr_prep.sv
hw/rtl/pbr_cell.sv
hw/rtl/pbr_finish.sv
hw/rtl/pursuit_bearing_range.sv
bench/pursuit_bearing_range_tb.sv
